FILE: hw/rtl/cctc_pkg.sv
`default_nettype none
package cctc_pkg;

   localparam int unsigned PageBytes = 4096;
   localparam int unsigned PageBits  = $clog2(PageBytes);

   typedef enum logic [1:0] {
      KIND_CTRL = 2'd0,
      KIND_READ = 2'd1,
      KIND_TICK = 2'd2,
      KIND_NONE = 2'd3
   } kind_type;

   typedef enum logic [2:0] {
      CSR_SLOT_EN  = 3'd0,
      CSR_SERIAL   = 3'd1,
      CSR_IRQ_EN   = 3'd2,
      CSR_ROM_SIZE = 3'd3,
      CSR_ADDR_MSK = 3'd4,
      CSR_CHIP_ID  = 3'd5
   } csr_index_type;

   localparam logic [7:0] CmdHeader  = 8'h00;
   localparam logic [7:0] CmdKey1    = 8'h3C;
   localparam logic [7:0] CmdData    = 8'hB7;
   localparam logic [7:0] CmdId1     = 8'h90;
   localparam logic [7:0] CmdId2     = 8'hB8;
   localparam logic [3:0] EncRead    = 4'h2;
   localparam logic [3:0] EncId      = 4'h1;
   localparam logic [3:0] EncLeave   = 4'hA;
   localparam logic [31:0] KeepMask  = 32'hA080_0000;
   localparam logic [31:0] BusyRdy   = 32'h8080_0000;
   localparam logic [31:0] LowRemap  = 32'h0000_8000;
   localparam logic [31:0] RemapMask = 32'h0000_01FF;

   typedef struct packed {
      kind_type    kind;
      logic        owner;
      logic [31:0] ctrl_value;
      logic [63:0] command;
      logic [31:0] rom_word;
   } item_type;

   typedef struct packed {
      logic [31:0] read_data;
      logic [31:0] control_readback;
      logic [7:0]  wait_cycles;
      logic        dma_request;
      logic        irq;
      logic [31:0] fetch_offset;
      logic        encrypted_mode;
   } result_type;

endpackage
`default_nettype wire

FILE: hw/rtl/cctc_if.sv
`default_nettype none
interface cctc_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  kind;
   logic        from_slot_owner;
   logic [31:0] ctrl_value;
   logic [63:0] command;
   logic [31:0] rom_word;
   modport source (output valid, kind, from_slot_owner, ctrl_value, command, rom_word,
                   input ready);
   modport sink (input valid, kind, from_slot_owner, ctrl_value, command, rom_word,
                 output ready);
endinterface

interface cctc_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] read_data;
   logic [31:0] control_readback;
   logic        busy_res;
   logic        word_ready;
   logic [7:0]  wait_cycles;
   logic        dma_request;
   logic        irq;
   logic [31:0] fetch_offset;
   logic        encrypted_mode;
   modport source (output valid, read_data, control_readback, busy_res, word_ready,
                   wait_cycles, dma_request, irq, fetch_offset, encrypted_mode,
                   input ready);
   modport sink (input valid, read_data, control_readback, busy_res, word_ready,
                 wait_cycles, dma_request, irq, fetch_offset, encrypted_mode,
                 output ready);
endinterface

interface cctc_csr_if;
   logic        valid;
   logic        ready;
   logic [2:0]  index;
   logic [31:0] data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

FILE: hw/rtl/cartridge_command_transfer_controller_core.sv
`default_nettype none
// Channel   Direction  Contents
// req_*     in         kind, from_slot_owner, ctrl_value, command, rom_word
// rsp_*     out        read_data, control_readback, status bits, wait, dma, irq, offset
// csr_*     in         register index and write data, always ready
//
// One word is accepted per cycle while the decode queue has room. A word waits in the
// decode queue and is then executed into the output register, which offers its
// result. The decode queue holds two words, so the request side keeps moving while
// a result waits to be taken, until the queue is full.
// Reset is synchronous and active high; it clears all control and state registers
// and loads the chip identification register with its default.
// A stalled response side fills the queue and then lowers req_ready.
module cartridge_command_transfer_controller_core (
   input wire logic   clock,
   input wire logic   reset,
   cctc_req_if.sink   req,
   cctc_rsp_if.source rsp,
   cctc_csr_if.sink   csr
);
   import cctc_pkg::*;

   item_type item;
   logic     item_valid;
   logic     item_take;

   // The front stage classifies and queues incoming words.
   cctc_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req        (req),
      .item       (item),
      .item_valid (item_valid),
      .item_take  (item_take)
   );

   // The back stage executes them in order against the controller state.
   cctc_back u_back (
      .clock      (clock),
      .reset      (reset),
      .item       (item),
      .item_valid (item_valid),
      .item_take  (item_take),
      .csr        (csr),
      .rsp        (rsp)
   );

endmodule
`default_nettype wire

FILE: hw/rtl/cctc_front.sv
`default_nettype none
// Takes request words, classifies them and holds them in a two-entry queue.
module cctc_front (
   input  wire logic              clock,
   input  wire logic              reset,
   cctc_req_if.sink               req,
   output cctc_pkg::item_type     item,
   output logic                   item_valid,
   input  wire logic              item_take
);
   import cctc_pkg::*;

   item_type  q_ff [2];
   item_type  q_in;
   logic      wr_ff, wr_in;
   logic      rd_ff, rd_in;
   logic [1:0] cnt_ff, cnt_in;
   logic      push;
   logic      pop;

   assign req.ready  = (cnt_ff != 2'd2);
   assign push       = req.valid && req.ready;
   assign pop        = item_take && (cnt_ff != 2'd0);
   assign item_valid = (cnt_ff != 2'd0);
   assign item       = q_ff[rd_ff];

   always_comb begin
      q_in.kind       = kind_type'(req.kind);
      q_in.owner      = req.from_slot_owner;
      q_in.ctrl_value = req.ctrl_value;
      q_in.command    = req.command;
      q_in.rom_word   = req.rom_word;
      wr_in  = push ? ~wr_ff : wr_ff;
      rd_in  = pop ? ~rd_ff : rd_ff;
      cnt_in = cnt_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ff] <= q_in;
      end
      if (reset) begin
         wr_ff  <= 1'b0;
         rd_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   a_cnt_range: assert property (@(posedge clock) disable iff (reset) cnt_ff != 2'd3)
      else $error("queue count out of range");
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      cnt_ff == 2'd2 |-> !push) else $error("queue overflow");
   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      pop |-> cnt_ff != 2'd0) else $error("pop from empty queue");

endmodule
`default_nettype wire

FILE: hw/rtl/cctc_back.sv
`default_nettype none
// Executes queued items against the controller state and registers the result.
module cctc_back (
   input  wire logic              clock,
   input  wire logic              reset,
   input  cctc_pkg::item_type     item,
   input  wire logic              item_valid,
   output logic                   item_take,
   cctc_csr_if.sink               csr,
   cctc_rsp_if.source             rsp
);
   import cctc_pkg::*;

   logic        slot_en_ff, serial_ff, irq_en_ff;
   logic [29:0] rom_size_ff;
   logic [28:0] addr_mask_ff;
   logic [31:0] chip_id_ff;

   logic [31:0] ctrl_ff, ctrl_in;
   logic        enc_ff, enc_in;
   logic [7:0]  code_ff, code_in;
   logic [14:0] len_ff, len_in;
   logic [14:0] cnt_ff, cnt_in;
   logic [31:0] addr_ff, addr_in;
   logic [31:0] latch_ff, latch_in;

   logic        out_v_ff;
   result_type  out_ff, out_in;

   logic        step;
   logic        go;
   logic [2:0]  bs;
   logic [7:0]  code;
   logic [31:0] data_a;
   logic [15:0] cnt_sum;
   logic [7:0]  scale;
   logic        fetch_now;
   logic [31:0] off_now;
   logic        fetch_new;
   logic [31:0] off_new;
   logic [32:0] off_end;

   localparam logic [31:0] PageMask = 32'(PageBytes - 1);

   assign csr.ready = 1'b1;
   assign item_take = item_valid && (!out_v_ff || rsp.ready);
   assign step      = item_take;

   // Offset of the next ROM fetch for a given state.
   function automatic logic [32:0] fetch_of(input logic e, input logic [7:0] c,
                                            input logic [31:0] a, input logic [14:0] n);
      logic [31:0] w;
      w = (a & ~PageMask) | ((a + {17'd0, n}) & PageMask);
      if (e) begin
         fetch_of = (c[7:4] == EncRead) ? {1'b1, w} : 33'd0;
      end else if (c == CmdHeader) begin
         fetch_of = {1'b1, {17'd0, n} & PageMask};
      end else if (c == CmdData) begin
         fetch_of = {1'b1, w};
      end else begin
         fetch_of = 33'd0;
      end
   endfunction

   always_comb begin
      ctrl_in  = ctrl_ff;
      enc_in   = enc_ff;
      code_in  = code_ff;
      len_in   = len_ff;
      cnt_in   = cnt_ff;
      addr_in  = addr_ff;
      latch_in = latch_ff;
      out_in   = '0;
      scale    = ctrl_ff[27] ? 8'd16 : 8'd10;
      bs       = ctrl_ff[26:24];
      code     = item.command[63:56];
      data_a   = {3'd0, item.command[52:24] & addr_mask_ff};
      go       = 1'b0;
      cnt_sum  = {1'b0, cnt_ff} + 16'd4;
      {fetch_now, off_now} = fetch_of(enc_ff, code_ff, addr_ff, cnt_ff);
      off_end  = {1'b0, off_now} + 33'd4;

      case (item.kind)
         KIND_CTRL: begin
            if (item.owner) begin
               go      = !ctrl_ff[31] && item.ctrl_value[31];
               ctrl_in = (ctrl_ff & KeepMask) | (item.ctrl_value & ~BusyRdy);
               if (go && slot_en_ff && !serial_ff) begin
                  bs      = ctrl_in[26:24];
                  code_in = code;
                  if (bs == 3'd0) begin
                     len_in = 15'd0;
                  end else if (bs == 3'd7) begin
                     len_in = 15'd4;
                  end else begin
                     len_in = 15'(16'h100 << bs);
                  end
                  cnt_in  = 15'd0;
                  addr_in = 32'd0;
                  if (enc_ff) begin
                     if (code[7:4] == EncLeave) begin
                        enc_in = 1'b0;
                     end else if (code[7:4] == EncRead) begin
                        addr_in = {17'd0, item.command[46:44], 12'd0};
                     end
                  end else if (code == CmdKey1) begin
                     enc_in = 1'b1;
                  end else if (code == CmdData) begin
                     addr_in = (data_a < LowRemap) ? (LowRemap + (data_a & RemapMask))
                                                   : data_a;
                  end
                  out_in.wait_cycles = (ctrl_in[27] ? 8'd16 : 8'd10) << 3;
                  ctrl_in[31] = 1'b1;
                  ctrl_in[23] = 1'b0;
               end
            end
         end
         KIND_READ: begin
            if (item.owner) begin
               if (cnt_sum < {1'b0, len_ff}) begin
                  cnt_in = cnt_sum[14:0];
                  out_in.wait_cycles = scale << 2;
                  ctrl_in[23] = 1'b0;
               end else if (cnt_sum == {1'b0, len_ff}) begin
                  cnt_in = cnt_sum[14:0];
                  ctrl_in = ctrl_ff & ~BusyRdy;
                  out_in.irq = irq_en_ff;
               end else begin
                  cnt_in = len_ff;
               end
               out_in.read_data = latch_ff;
            end
         end
         KIND_TICK: begin
            if (ctrl_ff[31]) begin
               if (len_ff == 15'd0) begin
                  ctrl_in = ctrl_ff & ~BusyRdy;
                  out_in.irq = irq_en_ff;
               end else begin
                  ctrl_in[23] = 1'b1;
                  out_in.dma_request = 1'b1;
                  if (fetch_now) begin
                     latch_in = (off_end > {3'd0, rom_size_ff}) ? '1 : item.rom_word;
                  end else if (enc_ff) begin
                     if (code_ff[7:4] == EncId) begin
                        latch_in = chip_id_ff;
                     end else if (code_ff[7:4] == EncLeave) begin
                        latch_in = 32'd0;
                     end else begin
                        latch_in = '1;
                     end
                  end else if (code_ff == CmdId1 || code_ff == CmdId2) begin
                     latch_in = chip_id_ff;
                  end else begin
                     latch_in = '1;
                  end
               end
            end
         end
         default: begin
         end
      endcase

      {fetch_new, off_new} = fetch_of(enc_in, code_in, addr_in, cnt_in);
      out_in.control_readback = ctrl_in;
      out_in.fetch_offset     = off_new;
      out_in.encrypted_mode   = enc_in;
   end

   always_ff @(posedge clock) begin
      if (step) begin
         out_ff <= out_in;
      end
      if (reset) begin
         slot_en_ff   <= 1'b0;
         serial_ff    <= 1'b0;
         irq_en_ff    <= 1'b0;
         rom_size_ff  <= '0;
         addr_mask_ff <= '0;
         chip_id_ff   <= 32'hC2;
         ctrl_ff      <= '0;
         enc_ff       <= 1'b0;
         code_ff      <= '0;
         len_ff       <= '0;
         cnt_ff       <= '0;
         addr_ff      <= '0;
         latch_ff     <= '0;
         out_v_ff     <= 1'b0;
      end else begin
         if (csr.valid) begin
            case (csr_index_type'(csr.index))
               CSR_SLOT_EN:  slot_en_ff   <= csr.data[0];
               CSR_SERIAL:   serial_ff    <= csr.data[0];
               CSR_IRQ_EN:   irq_en_ff    <= csr.data[0];
               CSR_ROM_SIZE: rom_size_ff  <= csr.data[29:0];
               CSR_ADDR_MSK: addr_mask_ff <= csr.data[28:0];
               CSR_CHIP_ID:  chip_id_ff   <= csr.data;
               default: begin
               end
            endcase
         end
         if (step) begin
            ctrl_ff  <= ctrl_in;
            enc_ff   <= enc_in;
            code_ff  <= code_in;
            len_ff   <= len_in;
            cnt_ff   <= cnt_in;
            addr_ff  <= addr_in;
            latch_ff <= latch_in;
         end
         if (step) begin
            out_v_ff <= 1'b1;
         end else if (rsp.ready) begin
            out_v_ff <= 1'b0;
         end
      end
   end

   assign rsp.valid            = out_v_ff;
   assign rsp.read_data        = out_ff.read_data;
   assign rsp.control_readback = out_ff.control_readback;
   assign rsp.busy_res         = out_ff.control_readback[31];
   assign rsp.word_ready       = out_ff.control_readback[23];
   assign rsp.wait_cycles      = out_ff.wait_cycles;
   assign rsp.dma_request      = out_ff.dma_request;
   assign rsp.irq              = out_ff.irq;
   assign rsp.fetch_offset     = out_ff.fetch_offset;
   assign rsp.encrypted_mode   = out_ff.encrypted_mode;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= len_ff || len_ff == 15'd0) else $error("count passed length");
   a_hold_result: assert property (@(posedge clock) disable iff (reset)
      out_v_ff && !rsp.ready |=> out_v_ff) else $error("result dropped");
   a_dma_busy: assert property (@(posedge clock) disable iff (reset)
      out_v_ff && out_ff.dma_request |-> out_ff.control_readback[23])
      else $error("DMA request without word ready");

endmodule
`default_nettype wire

FILE: dv/cctc_tb_if.sv
`default_nettype none
// Interfaces come from the RTL tree; this file only gathers testbench-side types.
package cctc_tb_pkg;
   import cctc_pkg::*;

   typedef struct {
      logic [31:0] read_data;
      logic [31:0] control_readback;
      logic        busy_res;
      logic        word_ready;
      logic [7:0]  wait_cycles;
      logic        dma_request;
      logic        irq;
      logic [31:0] fetch_offset;
      logic        encrypted_mode;
   } outcome_type;
endpackage
`default_nettype wire

FILE: dv/cartridge_command_transfer_controller_core_tb.sv
`default_nettype none
module cartridge_command_transfer_controller_core_tb;
   import cctc_pkg::*;
   import cctc_tb_pkg::*;

   logic clock = 1'b0;
   logic reset = 1'b1;

   cctc_req_if req ();
   cctc_rsp_if rsp ();
   cctc_csr_if csr ();

   cartridge_command_transfer_controller_core i_dut (
      .clock(clock), .reset(reset), .req(req), .rsp(rsp), .csr(csr)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Shadow copy of the configuration registers.
   logic        cfg_slot, cfg_serial, cfg_irq_en;
   logic [29:0] cfg_rom_size;
   logic [28:0] cfg_addr_mask;
   logic [31:0] cfg_chip_id;

   // Shadow copy of the controller state.
   logic [31:0] ctl;
   logic        enc;
   logic [7:0]  cmd_code;
   logic [14:0] xlen, xcnt;
   logic [31:0] xaddr, latch;

   item_type    pending_words[$];
   outcome_type expected_outcomes[$];
   int          failures = 0;
   int          send_idle_pct = 33;
   int          recv_idle_pct = 83;
   logic        stimulus_done = 1'b0;
   logic        hold_sender = 1'b0;
   int          quiet_cycles = 0;

   function automatic logic [31:0] page_wrapped();
      logic [31:0] pm;
      pm = PageBytes - 1;
      return (xaddr & ~pm) | ((xaddr + 32'(xcnt)) & pm);
   endfunction

   // Returns whether the next tick reads ROM, and at which byte offset.
   function automatic logic next_fetch(output logic [31:0] off);
      off = '0;
      if (enc) begin
         if (cmd_code[7:4] == EncRead) begin
            off = page_wrapped();
            return 1'b1;
         end
         return 1'b0;
      end
      if (cmd_code == CmdHeader) begin
         off = 32'(xcnt) & (PageBytes - 1);
         return 1'b1;
      end
      if (cmd_code == CmdData) begin
         off = page_wrapped();
         return 1'b1;
      end
      return 1'b0;
   endfunction

   function automatic logic [7:0] scale();
      return ctl[27] ? 8'd16 : 8'd10;
   endfunction

   // Works out the result of one accepted word and advances the shadow state.
   function automatic outcome_type controller_step(item_type it);
      outcome_type o;
      logic        go;
      logic [2:0]  bs;
      logic [31:0] a, off;
      logic [15:0] sum;
      o = '{default: '0};
      if (it.kind == KIND_CTRL && it.owner) begin
         go = ~ctl[31] & it.ctrl_value[31];
         ctl = (ctl & KeepMask) | (it.ctrl_value & ~BusyRdy);
         if (go && cfg_slot && !cfg_serial) begin
            bs = ctl[26:24];
            cmd_code = it.command[63:56];
            xlen = (bs == 0) ? 15'd0 : (bs == 7) ? 15'd4 : 15'(32'h100 << bs);
            xcnt = '0;
            xaddr = '0;
            if (enc) begin
               if (cmd_code[7:4] == EncLeave) enc = 1'b0;
               else if (cmd_code[7:4] == EncRead) xaddr = 32'(it.command[46:44]) << 12;
            end else if (cmd_code == CmdKey1) begin
               enc = 1'b1;
            end else if (cmd_code == CmdData) begin
               a = it.command[55:24] & 32'(cfg_addr_mask);
               if (a < LowRemap) a = LowRemap + (a & RemapMask);
               xaddr = a;
            end
            o.wait_cycles = 8'(scale() * 8);
            ctl[31] = 1'b1;
            ctl[23] = 1'b0;
         end
      end else if (it.kind == KIND_READ && it.owner) begin
         sum = {1'b0, xcnt} + 16'd4;
         if (sum < {1'b0, xlen}) begin
            o.wait_cycles = 8'(scale() * 4);
            ctl[23] = 1'b0;
         end else if (sum == {1'b0, xlen}) begin
            ctl = ctl & ~BusyRdy;
            o.irq = cfg_irq_en;
         end else begin
            sum = {1'b0, xlen};
         end
         xcnt = sum[14:0];
         o.read_data = latch;
      end else if (it.kind == KIND_TICK && ctl[31]) begin
         if (xlen == 0) begin
            ctl = ctl & ~BusyRdy;
            o.irq = cfg_irq_en;
         end else begin
            ctl[23] = 1'b1;
            if (next_fetch(off))
               latch = (33'(off) + 33'd4 > 33'(cfg_rom_size)) ? '1 : it.rom_word;
            else if (enc)
               latch = (cmd_code[7:4] == EncId) ? cfg_chip_id :
                       (cmd_code[7:4] == EncLeave) ? 32'd0 : '1;
            else if (cmd_code == CmdId1 || cmd_code == CmdId2)
               latch = cfg_chip_id;
            else
               latch = '1;
            o.dma_request = 1'b1;
         end
      end
      void'(next_fetch(off));
      o.control_readback = ctl;
      o.busy_res = ctl[31];
      o.word_ready = ctl[23];
      o.fetch_offset = off;
      o.encrypted_mode = enc;
      return o;
   endfunction

   // Driver: offers pending words with random gaps. The valid is only lowered
   // after an acceptance or when the slot was empty, never in the same step.
   always @(posedge clock) begin
      if (reset) begin
         req.valid <= 1'b0;
      end else begin
         if (req.valid && req.ready) begin
            expected_outcomes.push_back(controller_step(pending_words.pop_front()));
         end
         if ((!req.valid || req.ready) ) begin
            if (pending_words.size() > 0 && !hold_sender
                && !(req.valid && req.ready && pending_words.size() == 0)
                && $urandom_range(99) >= send_idle_pct) begin
               req.valid           <= 1'b1;
               req.kind            <= pending_words[0].kind;
               req.from_slot_owner <= pending_words[0].owner;
               req.ctrl_value      <= pending_words[0].ctrl_value;
               req.command         <= pending_words[0].command;
               req.rom_word        <= pending_words[0].rom_word;
            end else begin
               req.valid <= 1'b0;
            end
         end
      end
   end

   // Monitor: takes results with random stalls and checks every field.
   always @(posedge clock) begin
      outcome_type e;
      if (reset) begin
         rsp.ready <= 1'b0;
      end else begin
         if (rsp.valid && rsp.ready) begin
            if (expected_outcomes.size() == 0) begin
               $display("%0t: result word with nothing expected", $realtime);
               failures++;
            end else begin
               e = expected_outcomes.pop_front();
               if (rsp.read_data !== e.read_data || rsp.control_readback !== e.control_readback
                   || rsp.busy_res !== e.busy_res || rsp.word_ready !== e.word_ready
                   || rsp.wait_cycles !== e.wait_cycles || rsp.dma_request !== e.dma_request
                   || rsp.irq !== e.irq || rsp.fetch_offset !== e.fetch_offset
                   || rsp.encrypted_mode !== e.encrypted_mode) begin
                  $display("%0t: mismatch expected rd=%h ctl=%h b=%b r=%b w=%0d d=%b i=%b off=%h e=%b",
                           $realtime, e.read_data, e.control_readback, e.busy_res,
                           e.word_ready, e.wait_cycles, e.dma_request, e.irq,
                           e.fetch_offset, e.encrypted_mode);
                  $display("%0t: mismatch actual   rd=%h ctl=%h b=%b r=%b w=%0d d=%b i=%b off=%h e=%b",
                           $realtime, rsp.read_data, rsp.control_readback, rsp.busy_res,
                           rsp.word_ready, rsp.wait_cycles, rsp.dma_request, rsp.irq,
                           rsp.fetch_offset, rsp.encrypted_mode);
                  failures++;
               end
            end
         end
         rsp.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // Watchdog on cycles in which neither side accepts a word.
   always @(posedge clock) begin
      if ((req.valid && req.ready) || (rsp.valid && rsp.ready) || reset) begin
         quiet_cycles <= 0;
      end else if (expected_outcomes.size() > 0 || (pending_words.size() > 0 && !hold_sender)) begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles > 20000) begin
            $display("FAILURE");
            $finish;
         end
      end
   end

   function automatic item_type make_word(kind_type k, logic own, logic [31:0] v,
                                          logic [63:0] c, logic [31:0] w);
      item_type it;
      it.kind = k;
      it.owner = own;
      it.ctrl_value = v;
      it.command = c;
      it.rom_word = w;
      return it;
   endfunction

   function automatic logic [63:0] rand64();
      return {$urandom(), $urandom()};
   endfunction

   // A random command code biased towards the decoded ones.
   function automatic logic [7:0] pick_code();
      case ($urandom_range(9))
         0: return CmdHeader;
         1: return CmdKey1;
         2, 3: return CmdData;
         4: return CmdId1;
         5: return CmdId2;
         6: return {EncRead, 4'($urandom())};
         7: return {EncId, 4'($urandom())};
         8: return {EncLeave, 4'($urandom())};
         default: return 8'($urandom());
      endcase
   endfunction

   task automatic write_reg(csr_index_type idx, logic [31:0] val);
      csr.valid <= 1'b1;
      csr.index <= idx;
      csr.data  <= val;
      @(posedge clock);
      while (!csr.ready) @(posedge clock);
      csr.valid <= 1'b0;
      case (idx)
         CSR_SLOT_EN:  cfg_slot = val[0];
         CSR_SERIAL:   cfg_serial = val[0];
         CSR_IRQ_EN:   cfg_irq_en = val[0];
         CSR_ROM_SIZE: cfg_rom_size = val[29:0];
         CSR_ADDR_MSK: cfg_addr_mask = val[28:0];
         default:      cfg_chip_id = val;
      endcase
   endtask

   task automatic drain();
      while (pending_words.size() > 0 || req.valid || expected_outcomes.size() > 0)
         @(posedge clock);
      repeat (5) @(posedge clock);
   endtask

   // One well-formed transfer: start a command, then ticks and reads, with noise.
   task automatic queue_transfer();
      logic [31:0] v;
      int n;
      v = $urandom();
      v[31] = 1'b1;
      if ($urandom_range(3) != 0) v[26:24] = ($urandom_range(1) != 0) ? 3'd7 : 3'd1;
      pending_words.push_back(make_word(KIND_CTRL, 1'b1, v & ~32'h8000_0000, rand64(), $urandom()));
      pending_words.push_back(make_word(KIND_CTRL, ($urandom_range(9) != 0), v,
                                        {pick_code(), 56'(rand64())}, $urandom()));
      n = $urandom_range(1, 6);
      repeat (n) begin
         pending_words.push_back(make_word(KIND_TICK, 1'($urandom()), $urandom(), rand64(),
                                           $urandom()));
         pending_words.push_back(make_word(($urandom_range(7) == 0) ?
                                           kind_type'(2'($urandom())) : KIND_READ,
                                           ($urandom_range(9) != 0), $urandom(), rand64(), $urandom()));
      end
   endtask

   initial begin
      int phase;
      req.valid = 1'b0; req.kind = '0; req.from_slot_owner = 1'b0;
      req.ctrl_value = '0; req.command = '0; req.rom_word = '0;
      rsp.ready = 1'b0;
      csr.valid = 1'b0; csr.index = CSR_SLOT_EN; csr.data = '0;
      cfg_slot = 0; cfg_serial = 0; cfg_irq_en = 0; cfg_rom_size = 0; cfg_addr_mask = 0;
      cfg_chip_id = 32'hC2;
      ctl = 0; enc = 0; cmd_code = 0; xlen = 0; xcnt = 0; xaddr = 0; latch = 0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed words with the reset configuration: nothing may start.
      pending_words.push_back(make_word(KIND_CTRL, 1'b1, 32'hFFFF_FFFF, '1, '1));
      pending_words.push_back(make_word(KIND_TICK, 1'b1, '0, '0, '1));
      pending_words.push_back(make_word(KIND_NONE, 1'b1, '1, '1, '1));
      drain();

      write_reg(CSR_SLOT_EN, 32'd1);
      write_reg(CSR_SERIAL, 32'd0);
      write_reg(CSR_IRQ_EN, 32'd1);
      write_reg(CSR_ROM_SIZE, 32'h2000_0000);
      write_reg(CSR_ADDR_MSK, 32'h1FFF_FFFF);
      write_reg(CSR_CHIP_ID, 32'hFFFF_FFFF);
      // Zero length, header, low-address data read, key, foreign write, encrypted read, leave.
      pending_words.push_back(make_word(KIND_CTRL, 1'b1, 32'h8000_0000, {CmdId1, 56'd0}, '0));
      pending_words.push_back(make_word(KIND_TICK, 1'b0, '0, '0, '0));
      pending_words.push_back(make_word(KIND_CTRL, 1'b1, 32'h8F00_0000, {CmdHeader, 56'd0}, '0));
      pending_words.push_back(make_word(KIND_TICK, 1'b1, '0, '0, 32'h1234_5678));
      pending_words.push_back(make_word(KIND_READ, 1'b1, '0, '0, '0));
      pending_words.push_back(make_word(KIND_READ, 1'b1, '0, '0, '0));
      pending_words.push_back(make_word(KIND_READ, 1'b0, '0, '0, '0));
      pending_words.push_back(make_word(KIND_CTRL, 1'b1, 32'h0700_0000, '0, '0));
      pending_words.push_back(make_word(KIND_CTRL, 1'b1, 32'h8700_0000,
                                        {CmdData, 32'h0000_7FFF, 24'd0}, '0));
      pending_words.push_back(make_word(KIND_TICK, 1'b1, '0, '0, '1));
      pending_words.push_back(make_word(KIND_CTRL, 1'b1, 32'h2100_0000, '0, '0));
      pending_words.push_back(make_word(KIND_CTRL, 1'b1, 32'h8100_0000, {CmdKey1, 56'd0}, '0));
      pending_words.push_back(make_word(KIND_CTRL, 1'b0, 32'h0000_0000, '0, '0));
      pending_words.push_back(make_word(KIND_CTRL, 1'b1, 32'h0100_0000, '0, '0));
      pending_words.push_back(make_word(KIND_CTRL, 1'b1, 32'h8100_0000,
                                        {8'h2F, 8'h70, 48'd0}, '0));
      pending_words.push_back(make_word(KIND_TICK, 1'b1, '0, '0, 32'hA5A5_A5A5));
      pending_words.push_back(make_word(KIND_READ, 1'b1, '0, '0, '0));
      pending_words.push_back(make_word(KIND_CTRL, 1'b1, 32'h0100_0000, '0, '0));
      pending_words.push_back(make_word(KIND_CTRL, 1'b1, 32'h8100_0000, {8'hA0, 56'd0}, '0));
      pending_words.push_back(make_word(KIND_TICK, 1'b1, '0, '0, '0));
      drain();

      // Random phases under shifting configuration and idling patterns.
      for (phase = 0; phase < 12; phase++) begin
         if (phase == 4) begin send_idle_pct = 83; recv_idle_pct = 33; end
         if (phase == 8) begin send_idle_pct = 0;  recv_idle_pct = 0;  end
         write_reg(CSR_SLOT_EN, 32'($urandom_range(5) != 0));
         write_reg(CSR_SERIAL, 32'($urandom_range(5) == 0));
         write_reg(CSR_IRQ_EN, $urandom());
         write_reg(CSR_ROM_SIZE, (phase % 3 == 0) ? 32'd0 :
                   (phase % 3 == 1) ? 32'h2000_0000 : $urandom_range(32'h10000));
         write_reg(CSR_ADDR_MSK, (phase % 2 == 0) ? 32'h1FFF_FFFF : $urandom());
         write_reg(CSR_CHIP_ID, $urandom());
         while (pending_words.size() < 115) begin
            if ($urandom_range(4) == 0)
               pending_words.push_back(make_word(kind_type'(2'($urandom())), 1'($urandom()),
                                                 $urandom(), rand64(), $urandom()));
            else
               queue_transfer();
         end
         if (phase == 6) begin
            // The sender holds back until every outstanding result is back.
            while (pending_words.size() > 60) @(posedge clock);
            hold_sender = 1'b1;
            while (req.valid || expected_outcomes.size() > 0) @(posedge clock);
            hold_sender = 1'b0;
         end
         drain();
      end
      stimulus_done = 1'b1;
      repeat (10) @(posedge clock);
      if (failures == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end
endmodule
`default_nettype wire
